### rtl/core/aabbpc_pkg.sv
// shared types and constants for the box pair collision block
// no dependencies; used by aabbpc_pair_test, aabb_pair_collision_mtv and the testbench
package aabbpc_pkg;

	localparam int MAX_ENTITIES = 8;
	localparam int COORD_BITS   = 16;
	localparam int AXES         = 3;

	// world bounds are exact sums, overlaps exact differences
	localparam int WORLD_W = COORD_BITS + 1;
	localparam int OV_W    = COORD_BITS + 2;

	localparam int IDX_W = $clog2(MAX_ENTITIES);
	localparam int CNT_W = $clog2(MAX_ENTITIES + 1);

	// result index and axis fields have fixed widths
	localparam int IDX_OUT_W = 3;
	localparam int AXIS_W    = 2;

	localparam int IN_FIELDS_W  = 3 * AXES * COORD_BITS;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = 2 * IDX_OUT_W + AXIS_W + OV_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	typedef enum logic [AXIS_W-1:0] {
		AXIS_X,
		AXIS_Y,
		AXIS_Z
	} axis_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_WALK,
		ST_FINISH
	} state_t;

	typedef logic signed [WORLD_W-1:0] world_t;
	typedef logic signed [OV_W-1:0]    ov_t;

	// one stored entity: world-space bounds and model flag
	typedef struct packed {
		logic                  model;
		world_t [AXES-1:0]     lo;
		world_t [AXES-1:0]     hi;
	} entry_t;

	// outcome of one pair test
	typedef struct packed {
		logic              hit;
		ov_t [AXES-1:0]    ov;
	} pair_res_t;

	// walk token traveling beside the memory read data
	typedef struct packed {
		logic             valid;
		logic             pair;
		logic             fin;
		logic [IDX_W-1:0] i;
		logic [IDX_W-1:0] j;
	} token_t;

	typedef struct packed {
		logic [IDX_OUT_W-1:0] first;
		logic [IDX_OUT_W-1:0] second;
		axis_t                axis;
		ov_t                  amount;
	} result_t;

endpackage

### rtl/core/aabb_pair_collision_mtv.sv
// 3d box broad phase: loads boxes, walks all pairs, emits translation vectors
// load: one entity per cycle, no result; a final one starts a walk over all n*(n-1)/2 pairs and a
// closing token; hits wait for the next hit or the close, last result via tok_s1, tok_s2, out reg
// throughput: one pair per cycle set by the two-port entity memory read; stalls downstream
// hold the whole walk pipeline; no entity is taken while a walk is being issued
// reset: arst_n asynchronous active low clears count, walk state and output valid; memory not cleared
module aabb_pair_collision_mtv (
	input  logic                                clk,
	input  logic                                arst_n,
	// entity requests
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// pos_x, pos_y, pos_z, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z (16 bits each)
	input  logic [aabbpc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// has_model
	input  logic                                s_axis_tuser,
	// final_entity
	input  logic                                s_axis_tlast,
	// result requests
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// first_index (3), second_index (3), mtv_axis (2), mtv_amount (18), zero fill
	output logic [aabbpc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	// no_hit
	output logic                                m_axis_tuser,
	// last_pair
	output logic                                m_axis_tlast
);

	localparam int CW = aabbpc_pkg::COORD_BITS;
	localparam int NA = aabbpc_pkg::AXES;

	// walk sequencer state
	aabbpc_pkg::state_t                  state_q, state_d;
	logic [aabbpc_pkg::CNT_W-1:0]        cnt_q, cnt_d, cnt_inc;
	logic [aabbpc_pkg::CNT_W-1:0]        n_q, n_d;
	logic [aabbpc_pkg::IDX_W-1:0]        i_q, i_d, j_q, j_d;
	aabbpc_pkg::token_t                  tok_d, tok_s1, tok_s2;

	// entity memory and its registered read ports
	aabbpc_pkg::entry_t                  mem_q [aabbpc_pkg::MAX_ENTITIES];
	aabbpc_pkg::entry_t                  wr_entry;
	aabbpc_pkg::entry_t                  ent_a_s1, ent_b_s1;
	aabbpc_pkg::pair_res_t               pt_res, res_s2;

	// result path: one held-back result so the final one can carry last
	aabbpc_pkg::result_t                 new_res, pend_q, out_q;
	logic                                pend_v_q;
	logic                                out_v_q, out_last_q, out_nohit_q;

	logic                                adv;
	logic                                accept;
	logic                                store_en;
	logic                                hit_s2;

	// the whole walk pipeline moves only when the output register is free
	assign adv           = !out_v_q || m_axis_tready;
	assign s_axis_tready = (state_q == aabbpc_pkg::ST_LOAD);
	assign accept        = s_axis_tvalid && s_axis_tready;
	// a full store drops the entity, a final one still starts the walk
	assign store_en      = accept && (cnt_q < aabbpc_pkg::CNT_W'(aabbpc_pkg::MAX_ENTITIES));
	assign cnt_inc       = store_en ? cnt_q + aabbpc_pkg::CNT_W'(1) : cnt_q;

	// world bounds are formed once at load time
	always_comb begin
		logic signed [CW-1:0] p_v, l_v, h_v;
		wr_entry       = '0;
		wr_entry.model = s_axis_tuser;
		for (int ax = 0; ax < NA; ax++) begin
			p_v = $signed(s_axis_tdata[ax*CW +: CW]);
			l_v = $signed(s_axis_tdata[(NA+ax)*CW +: CW]);
			h_v = $signed(s_axis_tdata[(2*NA+ax)*CW +: CW]);
			wr_entry.lo[ax] = aabbpc_pkg::WORLD_W'(p_v) + aabbpc_pkg::WORLD_W'(l_v);
			wr_entry.hi[ax] = aabbpc_pkg::WORLD_W'(p_v) + aabbpc_pkg::WORLD_W'(h_v);
		end
	end

	// writes happen only while loading and reads only while walking,
	// so the state machine keeps the two from touching the same entry
	always_ff @(posedge clk) begin
		if (store_en)
			mem_q[cnt_q[aabbpc_pkg::IDX_W-1:0]] <= wr_entry;
	end

	always_ff @(posedge clk) begin
		if (adv && (state_q == aabbpc_pkg::ST_WALK)) begin
			ent_a_s1 <= mem_q[i_q];
			ent_b_s1 <= mem_q[j_q];
		end
	end

	// pair walk: i from 0, j from i+1, both below the entity count
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		n_d     = n_q;
		i_d     = i_q;
		j_d     = j_q;
		tok_d   = '0;
		case (state_q)
			aabbpc_pkg::ST_LOAD: begin
				if (accept) begin
					cnt_d = cnt_inc;
					if (s_axis_tlast) begin
						n_d = cnt_inc;
						i_d = '0;
						j_d = aabbpc_pkg::IDX_W'(1);
						// fewer than two entries means no pair at all
						if (cnt_inc >= aabbpc_pkg::CNT_W'(2))
							state_d = aabbpc_pkg::ST_WALK;
						else
							state_d = aabbpc_pkg::ST_FINISH;
					end
				end
			end
			aabbpc_pkg::ST_WALK: begin
				if (adv) begin
					tok_d.valid = 1'b1;
					tok_d.pair  = 1'b1;
					tok_d.i     = i_q;
					tok_d.j     = j_q;
					if (aabbpc_pkg::CNT_W'(j_q) == n_q - aabbpc_pkg::CNT_W'(1)) begin
						if (aabbpc_pkg::CNT_W'(i_q) + aabbpc_pkg::CNT_W'(2) == n_q) begin
							state_d = aabbpc_pkg::ST_FINISH;
						end else begin
							i_d = i_q + aabbpc_pkg::IDX_W'(1);
							j_d = i_q + aabbpc_pkg::IDX_W'(2);
						end
					end else begin
						j_d = j_q + aabbpc_pkg::IDX_W'(1);
					end
				end
			end
			aabbpc_pkg::ST_FINISH: begin
				// closing token flushes the held result or makes the no-hit one
				if (adv) begin
					tok_d.valid = 1'b1;
					tok_d.fin   = 1'b1;
					cnt_d       = '0;
					state_d     = aabbpc_pkg::ST_LOAD;
				end
			end
			default: begin
				state_d = aabbpc_pkg::ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aabbpc_pkg::ST_LOAD;
			cnt_q   <= '0;
			n_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			n_q     <= n_d;
			i_q     <= i_d;
			j_q     <= j_d;
		end
	end

	// stage 1 holds read data, stage 2 the pair test outcome
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
			tok_s2 <= '0;
		end else if (adv) begin
			tok_s1 <= tok_d;
			tok_s2 <= tok_s1;
		end
	end

	aabbpc_pair_test u_pair_test (
		.ent_a (ent_a_s1),
		.ent_b (ent_b_s1),
		.res   (pt_res)
	);

	always_ff @(posedge clk) begin
		if (adv)
			res_s2 <= pt_res;
	end

	// axis of least magnitude; x only when strictly least, else y, and a y/z tie goes to z
	always_comb begin
		logic [aabbpc_pkg::OV_W-1:0] mag [NA];
		for (int ax = 0; ax < NA; ax++)
			mag[ax] = res_s2.ov[ax][aabbpc_pkg::OV_W-1] ? -res_s2.ov[ax] : res_s2.ov[ax];
		new_res        = '0;
		new_res.first  = aabbpc_pkg::IDX_OUT_W'(tok_s2.i);
		new_res.second = aabbpc_pkg::IDX_OUT_W'(tok_s2.j);
		if ((mag[0] < mag[1]) && (mag[0] < mag[2])) begin
			new_res.axis   = aabbpc_pkg::AXIS_X;
			new_res.amount = res_s2.ov[0];
		end else if (mag[1] < mag[2]) begin
			new_res.axis   = aabbpc_pkg::AXIS_Y;
			new_res.amount = res_s2.ov[1];
		end else begin
			new_res.axis   = aabbpc_pkg::AXIS_Z;
			new_res.amount = res_s2.ov[2];
		end
	end

	assign hit_s2 = tok_s2.valid && tok_s2.pair && res_s2.hit;

	// a hit is held until the next hit or the closing token shows whether it is last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q    <= 1'b0;
			pend_q      <= '0;
			out_v_q     <= 1'b0;
			out_q       <= '0;
			out_last_q  <= 1'b0;
			out_nohit_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= 1'b0;
			if (hit_s2) begin
				if (pend_v_q) begin
					out_v_q     <= 1'b1;
					out_q       <= pend_q;
					out_last_q  <= 1'b0;
					out_nohit_q <= 1'b0;
				end
				pend_q   <= new_res;
				pend_v_q <= 1'b1;
			end else if (tok_s2.valid && tok_s2.fin) begin
				out_v_q    <= 1'b1;
				out_last_q <= 1'b1;
				pend_v_q   <= 1'b0;
				if (pend_v_q) begin
					out_q       <= pend_q;
					out_nohit_q <= 1'b0;
				end else begin
					out_q       <= '0;
					out_nohit_q <= 1'b1;
				end
			end
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = aabbpc_pkg::OUT_TDATA_W'({out_q.amount, out_q.axis,
		out_q.second, out_q.first});
	assign m_axis_tuser  = out_nohit_q;
	assign m_axis_tlast  = out_last_q;

	// a no-hit result always closes its run
	a_nohit_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("no-hit result without last");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= aabbpc_pkg::CNT_W'(aabbpc_pkg::MAX_ENTITIES))
		else $error("entity count beyond store depth");

	// walk indices stay ordered and inside the loaded set
	a_walk_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == aabbpc_pkg::ST_WALK |->
			(j_q > i_q) && (aabbpc_pkg::CNT_W'(j_q) < n_q))
		else $error("pair walk indices out of order or range");

	// the closing token always produces the last result and empties the hold register
	a_close_run: assert property (@(posedge clk) disable iff (!arst_n)
		adv && tok_s2.valid && tok_s2.fin |=> !pend_v_q && m_axis_tvalid && m_axis_tlast)
		else $error("walk closed without final result");

endmodule

### rtl/core/aabbpc_pair_test.sv
// overlap test and per-axis overlap amounts for one pair of stored boxes
// depends on aabbpc_pkg
module aabbpc_pair_test (
	input  aabbpc_pkg::entry_t    ent_a,
	input  aabbpc_pkg::entry_t    ent_b,
	output aabbpc_pkg::pair_res_t res
);

	always_comb begin
		logic                      hit_v;
		logic signed [aabbpc_pkg::WORLD_W-1:0] a_lo, a_hi, b_lo, b_hi;
		logic signed [aabbpc_pkg::OV_W-1:0]    d_ab, d_ba, ov_v;
		hit_v = ent_a.model & ent_b.model;
		res   = '0;
		for (int ax = 0; ax < aabbpc_pkg::AXES; ax++) begin
			a_lo = $signed(ent_a.lo[ax]);
			a_hi = $signed(ent_a.hi[ax]);
			b_lo = $signed(ent_b.lo[ax]);
			b_hi = $signed(ent_b.hi[ax]);
			// inclusive test on each axis
			if (!((a_hi >= b_lo) && (a_lo <= b_hi)))
				hit_v = 1'b0;
			d_ab = aabbpc_pkg::OV_W'(a_hi) - aabbpc_pkg::OV_W'(b_lo);
			d_ba = aabbpc_pkg::OV_W'(b_hi) - aabbpc_pkg::OV_W'(a_lo);
			ov_v = (d_ab < d_ba) ? d_ab : d_ba;
			// y overlap is reported negated
			if (aabbpc_pkg::axis_t'(ax) == aabbpc_pkg::AXIS_Y)
				res.ov[ax] = -ov_v;
			else
				res.ov[ax] = ov_v;
		end
		res.hit = hit_v;
	end

endmodule

### tb/aabb_pair_collision_checker.sv
`timescale 1ns / 1ps
// checker for the box pair collision block: watches both streams, predicts pair results
// from entity requests and compares them field by field; depends on aabbpc_pkg
module aabb_pair_collision_checker
	import aabbpc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	// pos_x, pos_y, pos_z, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z (16 bits each)
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// has_model
	input  logic                   s_axis_tuser,
	// final_entity
	input  logic                   s_axis_tlast,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// first_index (3), second_index (3), mtv_axis (2), mtv_amount (18), zero fill
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// no_hit
	input  logic                   m_axis_tuser,
	// last_pair
	input  logic                   m_axis_tlast,
	output int                     fail_count,
	output int                     outstanding,
	output int                     results_checked,
	output int                     empty_walks
);

	localparam int AXIS_LSB = 2 * IDX_OUT_W;
	localparam int AMT_LSB  = AXIS_LSB + AXIS_W;
	localparam int FILL_LSB = AMT_LSB + OV_W;

	typedef struct packed {
		logic [IDX_OUT_W-1:0] first;
		logic [IDX_OUT_W-1:0] second;
		axis_t                axis;
		ov_t                  amount;
		logic                 no_hit;
		logic                 last;
	} pair_report_t;

	entry_t       boxes [MAX_ENTITIES];
	int           box_count = 0;
	pair_report_t pair_reports_q [$];
	pair_report_t want;
	int           mismatches = 0;
	int           pending = 0;
	int           checked = 0;
	int           no_hit_seen = 0;

	assign fail_count      = mismatches;
	assign outstanding     = pending;
	assign results_checked = checked;
	assign empty_walks     = no_hit_seen;

	task automatic report_mismatch(input string what, input int exp_val, input int got_val);
		$display("result %0d: %s expected %0d, got %0d", checked, what, exp_val, got_val);
		mismatches++;
	endtask

	// store one box in world coordinates; a final request walks all model pairs
	task automatic load_entity(input logic [IN_TDATA_W-1:0] d, input logic model,
			input logic fin);
		int           pos, lo, hi;
		int           a_lo, a_hi, b_lo, b_hi;
		int           ov [AXES];
		int           mag [AXES];
		bit           hit;
		int           found;
		pair_report_t r;
		if (box_count < MAX_ENTITIES) begin
			for (int ax = 0; ax < AXES; ax++) begin
				pos = $signed(d[COORD_BITS*ax +: COORD_BITS]);
				lo  = $signed(d[COORD_BITS*(AXES+ax) +: COORD_BITS]);
				hi  = $signed(d[COORD_BITS*(2*AXES+ax) +: COORD_BITS]);
				boxes[box_count].lo[ax] = world_t'(pos + lo);
				boxes[box_count].hi[ax] = world_t'(pos + hi);
			end
			boxes[box_count].model = model;
			box_count++;
		end
		if (!fin)
			return;
		found = 0;
		for (int i = 0; i < box_count; i++) begin
			if (!boxes[i].model)
				continue;
			for (int j = i + 1; j < box_count; j++) begin
				if (!boxes[j].model)
					continue;
				hit = 1'b1;
				for (int ax = 0; ax < AXES; ax++) begin
					a_lo = boxes[i].lo[ax];
					a_hi = boxes[i].hi[ax];
					b_lo = boxes[j].lo[ax];
					b_hi = boxes[j].hi[ax];
					if (!(a_hi >= b_lo && a_lo <= b_hi))
						hit = 1'b0;
					ov[ax] = (a_hi - b_lo < b_hi - a_lo) ? a_hi - b_lo : b_hi - a_lo;
				end
				if (!hit)
					continue;
				ov[AXIS_Y] = -ov[AXIS_Y];
				for (int ax = 0; ax < AXES; ax++)
					mag[ax] = (ov[ax] < 0) ? -ov[ax] : ov[ax];
				r = '0;
				r.first  = i[IDX_OUT_W-1:0];
				r.second = j[IDX_OUT_W-1:0];
				// strict on x, else y, and a y/z tie falls to z
				if (mag[AXIS_X] < mag[AXIS_Y] && mag[AXIS_X] < mag[AXIS_Z]) begin
					r.axis   = AXIS_X;
					r.amount = ov_t'(ov[AXIS_X]);
				end else if (mag[AXIS_Y] < mag[AXIS_Z]) begin
					r.axis   = AXIS_Y;
					r.amount = ov_t'(ov[AXIS_Y]);
				end else begin
					r.axis   = AXIS_Z;
					r.amount = ov_t'(ov[AXIS_Z]);
				end
				pair_reports_q.push_back(r);
				found++;
			end
		end
		if (found == 0) begin
			r = '0;
			r.no_hit = 1'b1;
			pair_reports_q.push_back(r);
		end
		pair_reports_q[pair_reports_q.size()-1].last = 1'b1;
		box_count = 0;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				load_entity(s_axis_tdata, s_axis_tuser, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				if (pair_reports_q.size() == 0) begin
					report_mismatch("unexpected result, pending count", 0, 1);
				end else begin
					want = pair_reports_q.pop_front();
					if (m_axis_tdata[0 +: IDX_OUT_W] !== want.first)
						report_mismatch("first_index", want.first, m_axis_tdata[0 +: IDX_OUT_W]);
					if (m_axis_tdata[IDX_OUT_W +: IDX_OUT_W] !== want.second)
						report_mismatch("second_index", want.second,
							m_axis_tdata[IDX_OUT_W +: IDX_OUT_W]);
					if (m_axis_tdata[AXIS_LSB +: AXIS_W] !== want.axis)
						report_mismatch("mtv_axis", want.axis, m_axis_tdata[AXIS_LSB +: AXIS_W]);
					if (m_axis_tdata[AMT_LSB +: OV_W] !== want.amount)
						report_mismatch("mtv_amount", $signed(want.amount),
							$signed(m_axis_tdata[AMT_LSB +: OV_W]));
					if (m_axis_tdata[OUT_TDATA_W-1:FILL_LSB] !== '0)
						report_mismatch("zero fill", 0, m_axis_tdata[OUT_TDATA_W-1:FILL_LSB]);
					if (m_axis_tuser !== want.no_hit)
						report_mismatch("no_hit", want.no_hit, m_axis_tuser);
					if (m_axis_tlast !== want.last)
						report_mismatch("last_pair", want.last, m_axis_tlast);
				end
				checked++;
				if (m_axis_tuser === 1'b1)
					no_hit_seen++;
			end
			pending = pair_reports_q.size();
		end
	end

endmodule

### tb/tb_aabb_pair_collision_mtv.sv
`timescale 1ns / 1ps
// testbench top for the box pair collision block: drives entity requests, paces results
// and gives the verdict; depends on aabbpc_pkg, the block and aabb_pair_collision_checker
module tb_aabb_pair_collision_mtv;
	import aabbpc_pkg::*;

	localparam int TARGET_ITEMS = 410;
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 400000;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// pos_x, pos_y, pos_z, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z (16 bits each)
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	// has_model
	logic                   s_axis_tuser = 1'b0;
	// final_entity
	logic                   s_axis_tlast = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// first_index (3), second_index (3), mtv_axis (2), mtv_amount (18), zero fill
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	// no_hit
	logic                   m_axis_tuser;
	// last_pair
	logic                   m_axis_tlast;

	int fail_count, outstanding, results_checked, empty_walks;

	// stimulus bookkeeping; load_fill mirrors the block's store so dropped
	// requests are not counted as stored
	int requests_sent = 0;
	int stored_items  = 0;
	int sets_sent     = 0;
	int load_fill     = 0;
	int cycle_count   = 0;
	bit tx_quiet      = 1'b0;
	bit hold_go       = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	aabb_pair_collision_mtv u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	aabb_pair_collision_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tuser    (s_axis_tuser),
		.s_axis_tlast    (s_axis_tlast),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tuser    (m_axis_tuser),
		.m_axis_tlast    (m_axis_tlast),
		.fail_count      (fail_count),
		.outstanding     (outstanding),
		.results_checked (results_checked),
		.empty_walks     (empty_walks)
	);

	// run guard: a hang or a lost result ends here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("cycle limit of %0d reached, %0d results still pending",
				CYCLE_LIMIT, outstanding);
			$display("== FAIL ==");
			$finish;
		end
	end

	// one entity request: random gap, then hold valid until the block takes it
	task automatic send_box(input int px, py, pz, lx, ly, lz, hx, hy, hz,
			input bit model, fin);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 6);
		// valid drops only when a gap follows, so it never toggles within one step
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {hz[15:0], hy[15:0], hx[15:0], lz[15:0], ly[15:0], lx[15:0],
			pz[15:0], py[15:0], px[15:0]};
		s_axis_tuser  <= model;
		s_axis_tlast  <= fin;
		do @(posedge clk); while (!s_axis_tready);
		requests_sent++;
		if (load_fill < MAX_ENTITIES) begin
			stored_items++;
			load_fill++;
		end
		if (fin) begin
			load_fill = 0;
			sets_sent++;
		end
	endtask

	// a set of boxes ending in a final request; clustered sets overlap often,
	// the others use any bit pattern with many extremes
	task automatic send_random_set(input int count, input bit clustered);
		int v [9];
		int t;
		for (int k = 0; k < count; k++) begin
			for (int f = 0; f < 9; f++) begin
				if (!clustered)
					v[f] = ($urandom_range(0, 3) == 0) ?
						($urandom_range(0, 1) ? 32767 : -32768) : int'($urandom);
				else if (f < AXES)
					v[f] = int'($urandom_range(0, 2047)) - 1024;
				else if (f < 2 * AXES)
					v[f] = -int'($urandom_range(0, 640));
				else
					v[f] = $urandom_range(0, 640);
			end
			// now and then an inverted box, min above max
			if (clustered && $urandom_range(0, 15) == 0) begin
				t    = v[3];
				v[3] = v[6];
				v[6] = t;
			end
			send_box(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8],
				$urandom_range(0, 7) != 0, k == count - 1);
		end
	endtask

	// sender goes quiet until every predicted result has been taken
	task automatic wait_for_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		@(posedge clk);
	endtask

	// result side: per result a random stall, quiet stretches
	// with no stall, and one long hold counted here when the sender asks
	initial begin : result_sink
		int rx_gap;
		int rx_quiet;
		rx_gap   = 0;
		rx_quiet = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_go) begin
				hold_go = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_gap = 0;
				m_axis_tready <= 1'b1;
			end else if (m_axis_tready) begin
				if (m_axis_tvalid) begin
					if (rx_quiet > 0) begin
						rx_quiet--;
						rx_gap = 0;
					end else begin
						rx_gap = $urandom_range(0, 6);
						if ($urandom_range(0, 24) == 0)
							rx_quiet = 40;
					end
					if (rx_gap > 0)
						m_axis_tready <= 1'b0;
				end
			end else begin
				if (rx_gap > 0)
					rx_gap--;
				if (rx_gap == 0)
					m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		int set_len;
		int pick;
		bit held;
		bit drained;
		held    = 1'b0;
		drained = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// coordinate extremes: touching boxes at the top corner give zero overlap
		send_box(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 1, 0);
		send_box(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 1, 1);
		// most negative world bounds against the most positive
		send_box(-32768, -32768, -32768, -32768, -32768, -32768, 32767, 32767, 32767, 1, 0);
		send_box(32767, 32767, 32767, -32768, -32768, -32768, 32767, 32767, 32767, 1, 1);

		// axis choice: x strictly least, y least (negated), z least, x/y tie, full tie
		send_box(0, 0, 0, -256, -256, -256, 256, 256, 256, 1, 0);
		send_box(300, 0, 0, -256, -256, -256, 256, 256, 256, 1, 0);
		send_box(0, -300, 0, -256, -256, -256, 256, 256, 256, 1, 0);
		send_box(0, 0, 300, -256, -256, -256, 256, 256, 256, 1, 0);
		send_box(200, 200, 0, -256, -256, -256, 256, 256, 256, 1, 0);
		send_box(100, 100, 100, -256, -256, -256, 256, 256, 256, 1, 1);

		// overlapping boxes where one has no model: walk ends with no hit
		send_box(0, 0, 0, -256, -256, -256, 256, 256, 256, 1, 0);
		send_box(0, 0, 0, -256, -256, -256, 256, 256, 256, 0, 1);
		// a lone final entity: no pair at all
		send_box(5, -5, 5, -16, -16, -16, 16, 16, 16, 1, 1);
		// inverted box inside a large one
		send_box(0, 0, 0, 256, 256, 256, -256, -256, -256, 1, 0);
		send_box(0, 0, 0, -1024, -1024, -1024, 1024, 1024, 1024, 1, 1);
		// store overflow: the final request is dropped but still starts the walk
		send_random_set(MAX_ENTITIES + 1, 1'b1);

		while (stored_items < TARGET_ITEMS) begin
			tx_quiet = ($urandom_range(0, 4) == 0);
			if (!held && stored_items > 120) begin
				// results held back while full, overlapping sets keep coming
				held    = 1'b1;
				hold_go = 1'b1;
				repeat (4) send_random_set(MAX_ENTITIES, 1'b1);
			end else if (!drained && stored_items > 260) begin
				drained = 1'b1;
				wait_for_results();
			end else begin
				pick = $urandom_range(0, 19);
				if (pick == 0)
					set_len = 1;
				else if (pick < 3)
					set_len = $urandom_range(MAX_ENTITIES + 1, MAX_ENTITIES + 3);
				else
					set_len = $urandom_range(2, MAX_ENTITIES);
				send_random_set(set_len, $urandom_range(0, 4) != 0);
			end
		end

		wait_for_results();
		repeat (30) @(posedge clk);
		$display("covered %0d entity requests (%0d stored) in %0d sets: extremes, axis ties,",
			requests_sent, stored_items, sets_sent);
		$display("model-less and overflowing sets, a %0d-cycle result hold; %0d results, %0d empty",
			HOLD_CYCLES, results_checked, empty_walks);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
